// ===== src/degenerate_sequence_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the degenerate sequence tokenizer
// Shared helpers for concurrent checks clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DEGENERATE_SEQUENCE_TOKENIZER_MACROS_SVH
`define DEGENERATE_SEQUENCE_TOKENIZER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define DST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// Degenerate sequence tokenizer package
// Shared types, codes, register layout and the protein letter table.
// ----------------------------------------------------------------------------
package dst_pkg;

  // Largest general alphabet and width of a letter code.
  localparam int unsigned ALPHABET_MAX = 32;
  localparam int unsigned CODE_W       = 6;

  // Command queue between front and back end.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Character constants.
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_U     = 8'h55;
  localparam logic [7:0] CHAR_Z     = 8'h5a;
  localparam logic [7:0] CASE_GAP   = 8'd32;

  // Set letter count saturates here.
  localparam logic [1:0] SET_MIN = 2'd2;

  // Register reset values.
  localparam logic [1:0] RST_MODE  = 2'd1;
  localparam logic [7:0] RST_OPEN  = 8'd123;
  localparam logic [7:0] RST_CLOSE = 8'd125;

  typedef enum logic [2:0] {
    EV_RUN_LETTER = 3'd0,
    EV_SET_LETTER = 3'd1,
    EV_RUN_CLOSED = 3'd2,
    EV_SET_CLOSED = 3'd3,
    EV_DONE       = 3'd4,
    EV_ERROR      = 3'd5
  } event_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_CHAR     = 3'd1,
    ERR_SHORT_SET    = 3'd2,
    ERR_EMPTY        = 3'd3,
    ERR_UNTERMINATED = 3'd4
  } error_e;

  typedef enum logic [1:0] {
    MODE_GENERAL = 2'd0,
    MODE_DNA     = 2'd1,
    MODE_PROTEIN = 2'd2
  } alpha_mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_OPEN   = 3'd1,
    REG_CLOSE  = 3'd2,
    REG_LENGTH = 3'd3,
    REG_WORD0  = 3'd4,
    REG_WORD1  = 3'd5,
    REG_WORD2  = 3'd6,
    REG_WORD3  = 3'd7
  } reg_idx_e;

  // Configuration seen by the front end.
  typedef struct packed {
    logic [1:0]        alphabet_mode;
    logic [7:0]        open_char;
    logic [7:0]        close_char;
    logic [5:0]        alphabet_length;
    logic [3:0][63:0]  alphabet_word;
  } cfg_t;

  // One queued command: one result, or run closed followed by a final result.
  typedef struct packed {
    logic              two_results;
    event_kind_e       kind;
    logic [CODE_W-1:0] code;
    error_e            err;
  } cmd_t;

  // Protein code for an upper-case letter offset from 'A', zero when invalid.
  function automatic logic [CODE_W-1:0] prot_code(input logic [4:0] idx);
    logic [CODE_W-1:0] r;
    case (idx)
      5'd0:    r = 6'd1;
      5'd2:    r = 6'd2;
      5'd3:    r = 6'd3;
      5'd4:    r = 6'd4;
      5'd5:    r = 6'd5;
      5'd6:    r = 6'd6;
      5'd7:    r = 6'd7;
      5'd8:    r = 6'd8;
      5'd10:   r = 6'd9;
      5'd11:   r = 6'd10;
      5'd12:   r = 6'd11;
      5'd13:   r = 6'd12;
      5'd14:   r = 6'd13;
      5'd15:   r = 6'd14;
      5'd16:   r = 6'd15;
      5'd17:   r = 6'd16;
      5'd18:   r = 6'd17;
      5'd19:   r = 6'd18;
      5'd20:   r = 6'd19;
      5'd21:   r = 6'd20;
      5'd22:   r = 6'd21;
      5'd24:   r = 6'd22;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/dst_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer stream interfaces
// Valid/ready channels for sequence bytes in and token events out.
// ----------------------------------------------------------------------------

// Sequence byte channel.
interface dst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_sequence;

  modport source (output valid, output char_byte, output end_of_sequence, input ready);
  modport sink   (input valid, input char_byte, input end_of_sequence, output ready);
endinterface

// Token event channel.
interface dst_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [5:0] letter_code;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output event_kind, output letter_code, output error_code,
                  output last, input ready);
  modport sink   (input valid, input event_kind, input letter_code, input error_code,
                  input last, output ready);
endinterface

// ===== src/dst_regs.sv =====
// ----------------------------------------------------------------------------
// Tokenizer configuration registers
// APB-style register file holding the alphabet mode, set delimiters and the
// general alphabet.
// ----------------------------------------------------------------------------
module dst_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output dst_pkg::cfg_t cfg_o
);

  dst_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alphabet_mode   <= dst_pkg::RST_MODE;
      cfg_q.open_char       <= dst_pkg::RST_OPEN;
      cfg_q.close_char      <= dst_pkg::RST_CLOSE;
      cfg_q.alphabet_length <= '0;
      cfg_q.alphabet_word   <= '0;
    end else if (wr_en) begin
      case (idx)
        dst_pkg::REG_MODE:   cfg_q.alphabet_mode    <= pwdata[1:0];
        dst_pkg::REG_OPEN:   cfg_q.open_char        <= pwdata[7:0];
        dst_pkg::REG_CLOSE:  cfg_q.close_char       <= pwdata[7:0];
        dst_pkg::REG_LENGTH: cfg_q.alphabet_length  <= pwdata[5:0];
        dst_pkg::REG_WORD0:  cfg_q.alphabet_word[0] <= pwdata;
        dst_pkg::REG_WORD1:  cfg_q.alphabet_word[1] <= pwdata;
        dst_pkg::REG_WORD2:  cfg_q.alphabet_word[2] <= pwdata;
        dst_pkg::REG_WORD3:  cfg_q.alphabet_word[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      dst_pkg::REG_MODE:   prdata = {62'd0, cfg_q.alphabet_mode};
      dst_pkg::REG_OPEN:   prdata = {56'd0, cfg_q.open_char};
      dst_pkg::REG_CLOSE:  prdata = {56'd0, cfg_q.close_char};
      dst_pkg::REG_LENGTH: prdata = {58'd0, cfg_q.alphabet_length};
      dst_pkg::REG_WORD0:  prdata = cfg_q.alphabet_word[0];
      dst_pkg::REG_WORD1:  prdata = cfg_q.alphabet_word[1];
      dst_pkg::REG_WORD2:  prdata = cfg_q.alphabet_word[2];
      dst_pkg::REG_WORD3:  prdata = cfg_q.alphabet_word[3];
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dst_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts one byte per cycle while the queue has room, classifies it, keeps
// the parse state and pushes a command for every byte that causes results.
// ----------------------------------------------------------------------------
`include "degenerate_sequence_tokenizer_macros.svh"

module dst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dst_pkg::cfg_t cfg_i,
  dst_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output dst_pkg::cmd_t cmd_o
);

  logic       run_q, run_d;
  logic [1:0] cnt_q, cnt_d;
  logic       seen_q, seen_d;
  logic       err_q, err_d;

  logic       acc;
  logic [7:0] c;
  logic [7:0] u;
  logic       blank;
  logic [5:0] n_eff;
  logic [255:0]                 alpha_flat;
  logic [dst_pkg::CODE_W-1:0]   gen_code;
  logic [dst_pkg::CODE_W-1:0]   code;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && !q_full_i;
  assign c          = in_i.char_byte;

  // Blank test and case folding.
  assign blank = (c == dst_pkg::CHAR_SPACE) ||
                 (c >= dst_pkg::CHAR_TAB && c <= dst_pkg::CHAR_CR);
  assign u     = (c >= dst_pkg::CHAR_LC_A && c <= dst_pkg::CHAR_LC_Z) ?
                 (c - dst_pkg::CASE_GAP) : c;

  // General alphabet: parallel compares, first match wins.
  assign alpha_flat = cfg_i.alphabet_word;
  assign n_eff      = (cfg_i.alphabet_length > 6'(dst_pkg::ALPHABET_MAX)) ?
                      6'(dst_pkg::ALPHABET_MAX) : cfg_i.alphabet_length;

  always_comb begin
    gen_code = '0;
    for (int i = dst_pkg::ALPHABET_MAX - 1; i >= 0; i--) begin
      if ((6'(i) < n_eff) && (alpha_flat[8*i +: 8] == c)) begin
        gen_code = 6'(i + 1);
      end
    end
  end

  // Letter code for the current mode.
  always_comb begin
    code = '0;
    if (cfg_i.alphabet_mode == dst_pkg::MODE_DNA) begin
      case (u)
        dst_pkg::CHAR_A: code = 6'd1;
        dst_pkg::CHAR_C: code = 6'd2;
        dst_pkg::CHAR_G: code = 6'd3;
        dst_pkg::CHAR_T: code = 6'd4;
        dst_pkg::CHAR_U: code = 6'd4;
        default:         code = '0;
      endcase
    end else if (cfg_i.alphabet_mode == dst_pkg::MODE_PROTEIN) begin
      if (u >= dst_pkg::CHAR_A && u <= dst_pkg::CHAR_Z) begin
        code = dst_pkg::prot_code(5'(u - dst_pkg::CHAR_A));
      end
    end else begin
      code = gen_code;
    end
  end

  // Parse decision and next state.
  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    err_d  = err_q;
    push_o = 1'b0;
    cmd_o  = '{two_results: 1'b0, kind: dst_pkg::EV_RUN_CLOSED, code: '0,
               err: dst_pkg::ERR_NONE};
    if (acc) begin
      if (in_i.end_of_sequence) begin
        push_o            = !err_q;
        cmd_o.two_results = 1'b1;
        if (!seen_q) begin
          cmd_o.kind = dst_pkg::EV_ERROR;
          cmd_o.err  = dst_pkg::ERR_EMPTY;
        end else if (!run_q) begin
          cmd_o.kind = dst_pkg::EV_ERROR;
          cmd_o.err  = dst_pkg::ERR_UNTERMINATED;
        end else begin
          cmd_o.kind = dst_pkg::EV_DONE;
        end
        run_d  = 1'b1;
        cnt_d  = '0;
        seen_d = 1'b0;
        err_d  = 1'b0;
      end else if (err_q || blank) begin
        push_o = 1'b0;
      end else if (c == cfg_i.open_char) begin
        push_o     = 1'b1;
        run_d      = 1'b0;
        cmd_o.kind = dst_pkg::EV_RUN_CLOSED;
      end else if (c == cfg_i.close_char) begin
        push_o = 1'b1;
        if (cnt_q < dst_pkg::SET_MIN) begin
          err_d      = 1'b1;
          cmd_o.kind = dst_pkg::EV_ERROR;
          cmd_o.err  = dst_pkg::ERR_SHORT_SET;
        end else begin
          cnt_d      = '0;
          run_d      = 1'b1;
          seen_d     = 1'b1;
          cmd_o.kind = dst_pkg::EV_SET_CLOSED;
        end
      end else if (code == '0) begin
        push_o     = 1'b1;
        err_d      = 1'b1;
        cmd_o.kind = dst_pkg::EV_ERROR;
        cmd_o.err  = dst_pkg::ERR_BAD_CHAR;
      end else begin
        push_o     = 1'b1;
        cmd_o.code = code;
        if (run_q) begin
          seen_d     = 1'b1;
          cmd_o.kind = dst_pkg::EV_RUN_LETTER;
        end else begin
          if (cnt_q < dst_pkg::SET_MIN) begin
            cnt_d = cnt_q + 2'd1;
          end
          cmd_o.kind = dst_pkg::EV_SET_LETTER;
        end
      end
    end
  end

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b1;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      err_q  <= err_d;
    end
  end

  // The set letter count saturates at two.
  `DST_ASSERT_NEVER(a_cnt_sat, cnt_q == 2'd3, "set letter count passed saturation")
  // Once latched, only an end marker may produce a command.
  `DST_ASSERT(a_err_quiet, (push_o && err_q) |-> in_i.end_of_sequence,
              "command pushed while an error is latched")
  // A latched error stays until an end marker is accepted.
  `DST_ASSERT(a_err_sticky, (err_q && !(acc && in_i.end_of_sequence)) |=> err_q,
              "latched error cleared without an end marker")

endmodule

// ===== src/dst_queue.sv =====
// ----------------------------------------------------------------------------
// Tokenizer command queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module dst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dst_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output dst_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);

  dst_pkg::cmd_t                entry_q [dst_pkg::QDEPTH];
  logic [dst_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [dst_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [dst_pkg::QCNT_W-1:0]   count_q;
  logic                         do_push;
  logic                         do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == dst_pkg::QCNT_W'(dst_pkg::QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + dst_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + dst_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + dst_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - dst_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/dst_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Expands queued commands into token events and holds them in an output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
`include "degenerate_sequence_tokenizer_macros.svh"

module dst_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dst_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  dst_out_if.source     out_o
);

  logic                       valid_q;
  logic                       phase_q;
  logic                       load;
  dst_pkg::event_kind_e       kind_q;
  logic [dst_pkg::CODE_W-1:0] code_q;
  dst_pkg::error_e            err_q;
  logic                       last_q;

  // The output register may take a new event when empty or being drained.
  assign load  = !valid_q || out_o.ready;
  assign pop_o = load && !empty_i && (!cmd_i.two_results || phase_q);

  // Control: valid flag and the phase of a two-event command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        phase_q <= cmd_i.two_results && !phase_q;
      end
    end
  end

  // Event payload.
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      if (cmd_i.two_results && !phase_q) begin
        kind_q <= dst_pkg::EV_RUN_CLOSED;
        code_q <= '0;
        err_q  <= dst_pkg::ERR_NONE;
        last_q <= 1'b0;
      end else begin
        kind_q <= cmd_i.kind;
        code_q <= cmd_i.code;
        err_q  <= cmd_i.err;
        last_q <= 1'b1;
      end
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.event_kind  = kind_q;
  assign out_o.letter_code = code_q;
  assign out_o.error_code  = err_q;
  assign out_o.last        = last_q;

  // Between the two events of an end marker, the first one is on show.
  `DST_ASSERT(a_phase_out, phase_q |-> (valid_q && !last_q &&
              kind_q == dst_pkg::EV_RUN_CLOSED), "end marker phase without run closed")
  // A letter event always carries a code.
  `DST_ASSERT(a_letter_code, (valid_q && (kind_q == dst_pkg::EV_RUN_LETTER ||
              kind_q == dst_pkg::EV_SET_LETTER)) |-> (code_q != '0),
              "letter event without a code")
  // Error events carry a cause and only they do.
  `DST_ASSERT(a_err_code, valid_q |-> ((kind_q == dst_pkg::EV_ERROR) ==
              (err_q != dst_pkg::ERR_NONE)), "error code does not match event kind")

endmodule

// ===== src/degenerate_sequence_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Degenerate sequence tokenizer
// Turns sequence text bytes into run, set and outcome events.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while its command queue has room;
// each byte's events are registered in that queue and then in the output
// register. Ordinary bytes cause at most one event, so the sustained rate is
// one byte per cycle while events are taken; an end marker causes two, and the
// four-entry command queue between classifier and event generator soaks up
// the extra one. Registers are written over the APB port at byte address 8*i
// and take effect on the next byte; no clearing pass is needed after reset.
module degenerate_sequence_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  dst_in_if.sink      in_i,
  dst_out_if.source   out_o
);

  dst_pkg::cfg_t cfg;
  dst_pkg::cmd_t push_cmd;
  dst_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  // Configuration registers.
  dst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Classifier and parse state.
  dst_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Command queue.
  dst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Event generator and output register.
  dst_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== sim/degenerate_sequence_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Degenerate sequence tokenizer testbench
// Drives sequence text bytes and end markers into the tokenizer under random
// idling on both channels, and predicts every token event from its own model
// of the tokenizer state and register file. Each event is checked field by
// field against the oldest prediction. The register file is read back over
// APB. Between phases the alphabet, mode and set delimiters are reprogrammed.
// ----------------------------------------------------------------------------
module degenerate_sequence_tokenizer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Cycles allowed after the last event for bytes that cause none.
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET  = 1800;
  localparam int PHASE_ITEMS  = 150;

  // Mode value with no meaning of its own; behaves as the general alphabet.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Protein codes for 'A' to 'Z'; zero marks a letter that is not valid.
  localparam logic [5:0] PROTEIN_CODE [26] = '{
    6'd1, 6'd0, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd0, 6'd9, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd0,
    6'd22, 6'd0
  };

  typedef struct packed {
    dst_pkg::event_kind_e kind;
    logic [5:0]           code;
    dst_pkg::error_e      err;
    logic                 last;
  } token_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  dst_in_if  in_if ();
  dst_out_if out_if ();

  degenerate_sequence_tokenizer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Register shadow, starting from the reset values.
  logic [1:0]  shadow_mode  = dst_pkg::RST_MODE;
  logic [7:0]  shadow_open  = dst_pkg::RST_OPEN;
  logic [7:0]  shadow_close = dst_pkg::RST_CLOSE;
  logic [5:0]  shadow_len   = '0;
  logic [63:0] shadow_word [4] = '{default: '0};

  // Tokenizer state of the prediction.
  logic       tok_run_mode  = 1'b1;
  logic [1:0] tok_set_count = '0;
  logic       tok_seen      = 1'b0;
  logic       tok_latched   = 1'b0;

  token_t expected_tokens [$];
  int     errors       = 0;
  int     items_sent   = 0;
  int     stall_cycles = 0;
  bit     in_quiet     = 1'b0;
  bit     out_quiet    = 1'b0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sink side: the event channel stalls at random unless a quiet stretch runs.
  always @(negedge clk_i) begin
    out_if.ready <= out_quiet || ($urandom_range(0, 99) >= 28);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Each accepted event is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d code %0d err %0d",
                 $time, out_if.event_kind, out_if.letter_code, out_if.error_code);
      end else begin
        want = expected_tokens.pop_front();
        if (out_if.event_kind !== want.kind)
          report_mismatch("event_kind", want.kind, out_if.event_kind);
        if (out_if.letter_code !== want.code)
          report_mismatch("letter_code", want.code, out_if.letter_code);
        if (out_if.error_code !== want.err)
          report_mismatch("error_code", want.err, out_if.error_code);
        if (out_if.last !== want.last)
          report_mismatch("last", want.last, out_if.last);
      end
    end
  end

  // Letter code of a byte under the current registers, zero when not valid.
  function automatic logic [5:0] letter_of(input logic [7:0] ch);
    logic [7:0]  up;
    logic [5:0]  code;
    int unsigned n;
    up   = (ch >= dst_pkg::CHAR_LC_A && ch <= dst_pkg::CHAR_LC_Z) ?
           ch - dst_pkg::CASE_GAP : ch;
    code = '0;
    n    = (shadow_len > dst_pkg::ALPHABET_MAX) ? dst_pkg::ALPHABET_MAX : shadow_len;
    if (shadow_mode == dst_pkg::MODE_DNA) begin
      if (up == dst_pkg::CHAR_A) code = 6'd1;
      else if (up == dst_pkg::CHAR_C) code = 6'd2;
      else if (up == dst_pkg::CHAR_G) code = 6'd3;
      else if (up == dst_pkg::CHAR_T || up == dst_pkg::CHAR_U) code = 6'd4;
    end else if (shadow_mode == dst_pkg::MODE_PROTEIN) begin
      if (up >= dst_pkg::CHAR_A && up <= dst_pkg::CHAR_Z)
        code = PROTEIN_CODE[up - dst_pkg::CHAR_A];
    end else begin
      // Walk backwards so that the first matching entry wins.
      for (int i = int'(n) - 1; i >= 0; i--) begin
        if (shadow_word[i / 8][8 * (i % 8) +: 8] == ch) code = 6'(i + 1);
      end
    end
    return code;
  endfunction

  function automatic void push_token(input dst_pkg::event_kind_e kind,
                                     input logic [5:0] code,
                                     input dst_pkg::error_e err, input logic last);
    token_t tok;
    tok = '{kind: kind, code: code, err: err, last: last};
    expected_tokens = {expected_tokens, tok};
  endfunction

  // Predicts the events caused by one accepted byte or end marker.
  function automatic void tokenize_byte(input logic [7:0] ch, input logic eos);
    logic [5:0] code;
    code = letter_of(ch);
    if (eos) begin
      if (!tok_latched) begin
        push_token(dst_pkg::EV_RUN_CLOSED, '0, dst_pkg::ERR_NONE, 1'b0);
        if (!tok_seen) push_token(dst_pkg::EV_ERROR, '0, dst_pkg::ERR_EMPTY, 1'b1);
        else if (!tok_run_mode)
          push_token(dst_pkg::EV_ERROR, '0, dst_pkg::ERR_UNTERMINATED, 1'b1);
        else push_token(dst_pkg::EV_DONE, '0, dst_pkg::ERR_NONE, 1'b1);
      end
      tok_run_mode  = 1'b1;
      tok_set_count = '0;
      tok_seen      = 1'b0;
      tok_latched   = 1'b0;
    end else if (tok_latched || ch == dst_pkg::CHAR_SPACE ||
                 (ch >= dst_pkg::CHAR_TAB && ch <= dst_pkg::CHAR_CR)) begin
      // Blanks and anything after an error cause nothing.
    end else if (ch == shadow_open) begin
      tok_run_mode = 1'b0;
      push_token(dst_pkg::EV_RUN_CLOSED, '0, dst_pkg::ERR_NONE, 1'b1);
    end else if (ch == shadow_close) begin
      if (tok_set_count < dst_pkg::SET_MIN) begin
        tok_latched = 1'b1;
        push_token(dst_pkg::EV_ERROR, '0, dst_pkg::ERR_SHORT_SET, 1'b1);
      end else begin
        tok_set_count = '0;
        tok_run_mode  = 1'b1;
        tok_seen      = 1'b1;
        push_token(dst_pkg::EV_SET_CLOSED, '0, dst_pkg::ERR_NONE, 1'b1);
      end
    end else if (code == '0) begin
      tok_latched = 1'b1;
      push_token(dst_pkg::EV_ERROR, '0, dst_pkg::ERR_BAD_CHAR, 1'b1);
    end else if (tok_run_mode) begin
      tok_seen = 1'b1;
      push_token(dst_pkg::EV_RUN_LETTER, code, dst_pkg::ERR_NONE, 1'b1);
    end else begin
      if (tok_set_count < dst_pkg::SET_MIN) tok_set_count = tok_set_count + 2'd1;
      push_token(dst_pkg::EV_SET_LETTER, code, dst_pkg::ERR_NONE, 1'b1);
    end
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input logic wr, input dst_pkg::reg_idx_e idx,
                              input logic [63:0] wdata, output logic [63:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input dst_pkg::reg_idx_e idx, input logic [63:0] val);
    logic [63:0] unused;
    apb_transfer(1'b1, idx, val, unused);
    case (idx)
      dst_pkg::REG_MODE:   shadow_mode  = val[1:0];
      dst_pkg::REG_OPEN:   shadow_open  = val[7:0];
      dst_pkg::REG_CLOSE:  shadow_close = val[7:0];
      dst_pkg::REG_LENGTH: shadow_len   = val[5:0];
      dst_pkg::REG_WORD0:  shadow_word[0] = val;
      dst_pkg::REG_WORD1:  shadow_word[1] = val;
      dst_pkg::REG_WORD2:  shadow_word[2] = val;
      default:             shadow_word[3] = val;
    endcase
  endtask

  // Register value as the shadow holds it, zero-extended.
  function automatic logic [63:0] shadow_value(input dst_pkg::reg_idx_e idx);
    case (idx)
      dst_pkg::REG_MODE:   return 64'(shadow_mode);
      dst_pkg::REG_OPEN:   return 64'(shadow_open);
      dst_pkg::REG_CLOSE:  return 64'(shadow_close);
      dst_pkg::REG_LENGTH: return 64'(shadow_len);
      dst_pkg::REG_WORD0:  return shadow_word[0];
      dst_pkg::REG_WORD1:  return shadow_word[1];
      dst_pkg::REG_WORD2:  return shadow_word[2];
      default:             return shadow_word[3];
    endcase
  endfunction

  // Sends one byte or end marker, at times with a random gap in front of it.
  task automatic send_item(input logic [7:0] ch, input logic eos);
    if (!in_quiet && $urandom_range(0, 99) < 25) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 1)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid           <= 1'b1;
    in_if.char_byte       <= ch;
    in_if.end_of_sequence <= eos;
    do @(posedge clk_i); while (!in_if.ready);
    tokenize_byte(ch, eos);
    items_sent++;
  endtask

  // Lets every predicted event arrive, then leaves the block to settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_blank();
    int unsigned r;
    r = $urandom_range(9, 14);
    return (r == 14) ? dst_pkg::CHAR_SPACE : 8'(r);
  endfunction

  // A byte that is a valid letter under the current registers where one exists.
  function automatic logic [7:0] pick_letter();
    logic [7:0]  ch;
    int unsigned n;
    int unsigned idx;
    n  = (shadow_len > dst_pkg::ALPHABET_MAX) ? dst_pkg::ALPHABET_MAX : shadow_len;
    ch = 8'($urandom_range(0, 255));
    if (shadow_mode == dst_pkg::MODE_DNA) begin
      case ($urandom_range(0, 4))
        0:       ch = dst_pkg::CHAR_A;
        1:       ch = dst_pkg::CHAR_C;
        2:       ch = dst_pkg::CHAR_G;
        3:       ch = dst_pkg::CHAR_T;
        default: ch = dst_pkg::CHAR_U;
      endcase
      if ($urandom_range(0, 1) != 0) ch = ch + dst_pkg::CASE_GAP;
    end else if (shadow_mode == dst_pkg::MODE_PROTEIN) begin
      do begin
        ch = dst_pkg::CHAR_A + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1) != 0) ch = ch + dst_pkg::CASE_GAP;
      end while (letter_of(ch) == '0);
    end else if (n != 0) begin
      idx = $urandom_range(0, n - 1);
      ch  = shadow_word[idx / 8][8 * (idx % 8) +: 8];
    end
    return ch;
  endfunction

  // A text byte, now and then preceded by a blank.
  task automatic send_text(input logic [7:0] ch);
    if ($urandom_range(0, 9) == 0) send_item(pick_blank(), 1'b0);
    send_item(ch, 1'b0);
  endtask

  task automatic send_letters(input int count);
    repeat (count) send_text(pick_letter());
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // One sequence: mostly well formed, the rest broken sets or noise.
  task automatic send_sequence();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 2) != 0) begin
          send_letters($urandom_range(1, 6));
        end else begin
          send_text(shadow_open);
          send_letters($urandom_range(2, 4));
          send_text(shadow_close);
        end
      end
    end else if (roll < 88) begin
      send_letters($urandom_range(0, 3));
      send_text(shadow_open);
      send_letters($urandom_range(0, 1));
      send_text(shadow_close);
    end else if (roll < 94) begin
      send_letters($urandom_range(0, 3));
      send_text(shadow_open);
      send_letters($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(0, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end
    send_end();
  endtask

  // Reset values, then all-ones writes, read back against the shadow.
  task automatic test_register_access();
    dst_pkg::reg_idx_e idx;
    logic [63:0]       got;
    for (int i = 0; i < 8; i++) begin
      idx = dst_pkg::reg_idx_e'(i);
      apb_transfer(1'b0, idx, '0, got);
      if (got !== shadow_value(idx)) report_mismatch("register read", shadow_value(idx), got);
      write_reg(idx, '1);
      apb_transfer(1'b0, idx, '0, got);
      if (got !== shadow_value(idx)) report_mismatch("register read", shadow_value(idx), got);
    end
    write_reg(dst_pkg::REG_MODE, 64'(dst_pkg::MODE_DNA));
    write_reg(dst_pkg::REG_OPEN, 64'(dst_pkg::RST_OPEN));
    write_reg(dst_pkg::REG_CLOSE, 64'(dst_pkg::RST_CLOSE));
  endtask

  // DNA text: empty sequence, folding, open inside a set, short and open sets, bad byte.
  task automatic test_dna_text();
    send_end();
    send_item("a", 1'b0);
    send_item(dst_pkg::RST_OPEN, 1'b0);
    send_item("C", 1'b0);
    send_item("u", 1'b0);
    send_item(dst_pkg::RST_OPEN, 1'b0);
    send_item("G", 1'b0);
    send_item(dst_pkg::RST_CLOSE, 1'b0);
    send_end();
    // Close with no set open, then a byte swallowed by the latched error.
    send_item(dst_pkg::RST_CLOSE, 1'b0);
    send_item("A", 1'b0);
    send_end();
    send_item("T", 1'b0);
    send_item(dst_pkg::RST_OPEN, 1'b0);
    send_item("A", 1'b0);
    send_end();
    send_item(8'hFF, 1'b0);
    send_end();
    wait_idle();
  endtask

  // General alphabet in the spare mode: long length, duplicate entries, one
  // delimiter for both open and close, case sensitivity.
  task automatic test_general_alphabet();
    write_reg(dst_pkg::REG_MODE, 64'(MODE_SPARE));
    write_reg(dst_pkg::REG_OPEN, 64'h7C);
    write_reg(dst_pkg::REG_CLOSE, 64'h7C);
    write_reg(dst_pkg::REG_LENGTH, 64'd40);
    write_reg(dst_pkg::REG_WORD0, 64'h4847_4645_4443_4141);
    write_reg(dst_pkg::REG_WORD1, 64'h0);
    write_reg(dst_pkg::REG_WORD2, 64'h0);
    write_reg(dst_pkg::REG_WORD3, 64'h5A00_0000_0000_0000);
    send_item("A", 1'b0);
    send_item(8'h7C, 1'b0);
    send_item("Z", 1'b0);
    send_item("H", 1'b0);
    send_item(8'h7C, 1'b0);
    send_item(8'h00, 1'b0);
    send_end();
    send_item("a", 1'b0);
    send_end();
    wait_idle();
  endtask

  // Protein letters with blanks as delimiters: the blanks must be skipped.
  task automatic test_protein_blanks();
    write_reg(dst_pkg::REG_MODE, 64'(dst_pkg::MODE_PROTEIN));
    write_reg(dst_pkg::REG_OPEN, 64'(dst_pkg::CHAR_SPACE));
    write_reg(dst_pkg::REG_CLOSE, 64'(dst_pkg::CHAR_TAB));
    send_item("y", 1'b0);
    send_item(dst_pkg::CHAR_SPACE, 1'b0);
    send_item("O", 1'b0);
    send_item(dst_pkg::CHAR_TAB, 1'b0);
    send_item(8'h80, 1'b0);
    send_end();
    wait_idle();
  endtask

  // Reprograms every register for one phase of the random test.
  task automatic configure_phase(input int phase);
    logic [7:0] delim;
    write_reg(dst_pkg::REG_MODE, (phase < 4) ? 64'(phase) : 64'($urandom_range(0, 3)));
    delim = 8'($urandom_range(0, 255));
    case (phase % 5)
      0: begin
        write_reg(dst_pkg::REG_OPEN, 64'(dst_pkg::RST_OPEN));
        write_reg(dst_pkg::REG_CLOSE, 64'(dst_pkg::RST_CLOSE));
      end
      1: begin
        write_reg(dst_pkg::REG_OPEN, 64'h00);
        write_reg(dst_pkg::REG_CLOSE, 64'hFF);
      end
      2: begin
        write_reg(dst_pkg::REG_OPEN, 64'hFF);
        write_reg(dst_pkg::REG_CLOSE, 64'h00);
      end
      3: begin
        write_reg(dst_pkg::REG_OPEN, 64'(delim));
        write_reg(dst_pkg::REG_CLOSE, 64'(delim));
      end
      default: begin
        write_reg(dst_pkg::REG_OPEN, 64'(delim));
        write_reg(dst_pkg::REG_CLOSE, 64'($urandom_range(0, 255)));
      end
    endcase
    case (phase % 5)
      0:       write_reg(dst_pkg::REG_LENGTH, 64'd32);
      1:       write_reg(dst_pkg::REG_LENGTH, 64'd63);
      2:       write_reg(dst_pkg::REG_LENGTH, 64'($urandom_range(1, 31)));
      3:       write_reg(dst_pkg::REG_LENGTH, 64'd0);
      default: write_reg(dst_pkg::REG_LENGTH, 64'($urandom_range(0, 63)));
    endcase
    for (int w = 0; w < 4; w++) begin
      if (phase % 7 == 5)
        write_reg(dst_pkg::reg_idx_e'(int'(dst_pkg::REG_WORD0) + w), '0);
      else if (phase % 7 == 6)
        write_reg(dst_pkg::reg_idx_e'(int'(dst_pkg::REG_WORD0) + w), '1);
      else
        write_reg(dst_pkg::reg_idx_e'(int'(dst_pkg::REG_WORD0) + w), {$urandom, $urandom});
    end
  endtask

  // Random sequences over a series of register settings; one phase runs with
  // no idling on either side.
  task automatic test_random_sequences();
    int phase_end;
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      wait_idle();
      configure_phase(phase);
      in_quiet  = (phase == 2);
      out_quiet = (phase == 2);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_sequence();
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_if.valid           = 1'b0;
    in_if.char_byte       = '0;
    in_if.end_of_sequence = 1'b0;
    out_if.ready          = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_dna_text();
    test_general_alphabet();
    test_protein_blanks();
    test_random_sequences();
    wait_idle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dst_pkg.sv
src/dst_if.sv
src/dst_regs.sv
src/dst_front.sv
src/dst_queue.sv
src/dst_back.sv
src/degenerate_sequence_tokenizer.sv
sim/degenerate_sequence_tokenizer_tb.sv
